// File: rtl/mqts_pkg.sv
// ----------------------------------------------------------------------------
// mqts_pkg
// Shared types, sizes and codes for the two-stack max queue.
// ----------------------------------------------------------------------------
package mqts_pkg;

    localparam int QUEUE_DEPTH = 1024;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    // operation codes on the input word
    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_DEQ = 2'd1;
    localparam logic [1:0] OP_MAX = 2'd2;

    // status codes on the output word
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_EMPTY = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    // command kinds between front and back
    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_DEQ = 2'd1;
    localparam logic [1:0] CMD_MAX = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    typedef struct packed {
        logic [1:0]                   operation;
        logic signed [DATA_WIDTH-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] data;
        logic [1:0]                   status;
    } t_out_word;

    typedef struct packed {
        logic [1:0]                   kind;
        logic signed [DATA_WIDTH-1:0] value;
    } t_cmd;

    // one stack entry: running maximum and the word itself
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] maxv;
        logic signed [DATA_WIDTH-1:0] val;
    } t_entry;

    function automatic logic signed [DATA_WIDTH-1:0] f_max(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

endpackage

// File: rtl/mqts_front.sv
// ----------------------------------------------------------------------------
// mqts_front
// Input stage: takes words and classifies them into commands.
// ----------------------------------------------------------------------------
module mqts_front
    import mqts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_word i_in_word,
    output logic     o_cmd_valid,
    input  logic     i_cmd_ready,
    output t_cmd     o_cmd
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_valid = r_valid && !i_cmd_ready;
        n_cmd   = r_cmd;
        if (i_in_valid && o_in_ready) begin
            n_valid     = 1'b1;
            n_cmd.value = i_in_word.value;
            unique case (i_in_word.operation)
                OP_ENQ:  n_cmd.kind = CMD_ENQ;
                OP_DEQ:  n_cmd.kind = CMD_DEQ;
                OP_MAX:  n_cmd.kind = CMD_MAX;
                default: n_cmd.kind = CMD_NOP;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule

// File: rtl/mqts_cmdq.sv
// ----------------------------------------------------------------------------
// mqts_cmdq
// Small command queue between the front and back stages.
// ----------------------------------------------------------------------------
module mqts_cmdq
    import mqts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr_valid,
    output logic o_wr_ready,
    input  t_cmd i_wr_cmd,
    output logic o_rd_valid,
    input  logic i_rd_ready,
    output t_cmd o_rd_cmd
);

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr_ptr;
    logic [CMDQ_PTR_W-1:0] r_rd_ptr;
    logic [CMDQ_CNT_W-1:0] r_cnt;
    logic                  wr_en;
    logic                  rd_en;

    assign o_wr_ready = (r_cnt != CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_cmd   = r_mem[r_rd_ptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

endmodule

// File: rtl/mqts_back.sv
// ----------------------------------------------------------------------------
// mqts_back
// Execution stage: owns both stacks and their maxima, runs one command at a
// time and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module mqts_back
    import mqts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ENQ  = 3'd1;
    localparam logic [2:0] ST_DEQ  = 3'd2;
    localparam logic [2:0] ST_XRD  = 3'd3;
    localparam logic [2:0] ST_XWR  = 3'd4;
    localparam logic [2:0] ST_MAX  = 3'd5;

    t_entry r_front_mem [QUEUE_DEPTH];
    t_entry r_back_mem  [QUEUE_DEPTH];
    t_entry r_front_rd;
    t_entry r_back_rd;

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [CNT_W-1:0]             r_fc;
    logic [CNT_W-1:0]             n_fc;
    logic [CNT_W-1:0]             r_bc;
    logic [CNT_W-1:0]             n_bc;
    logic signed [DATA_WIDTH-1:0] r_run;
    logic signed [DATA_WIDTH-1:0] n_run;
    t_cmd                         r_cmd;
    t_cmd                         n_cmd;
    logic                         r_out_valid;
    logic                         n_out_valid;
    t_out_word                    r_out;
    t_out_word                    n_out;

    logic                         f_we;
    logic                         b_we;
    logic [ADDR_W-1:0]            f_wa;
    logic [ADDR_W-1:0]            b_wa;
    t_entry                       f_wd;
    t_entry                       b_wd;
    logic [ADDR_W-1:0]            f_ra;
    logic [ADDR_W-1:0]            b_ra;
    logic                         full;
    logic signed [DATA_WIDTH-1:0] xv;
    logic signed [DATA_WIDTH-1:0] xmax;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign full = ({1'b0, r_fc} + {1'b0, r_bc}) >= SUM_W'(QUEUE_DEPTH);
    assign xv   = r_back_rd.val;
    assign xmax = (r_fc == '0) ? xv : f_max(r_run, xv);

    always_comb begin
        n_state     = r_state;
        n_fc        = r_fc;
        n_bc        = r_bc;
        n_run       = r_run;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_cmd_ready = 1'b0;
        f_we        = 1'b0;
        b_we        = 1'b0;
        f_wa        = r_fc[ADDR_W-1:0];
        b_wa        = r_bc[ADDR_W-1:0];
        f_wd        = '0;
        b_wd        = '0;
        f_ra        = ADDR_W'(r_fc - 1'b1);
        b_ra        = ADDR_W'(r_bc - 1'b1);

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && !r_out_valid) begin
                    o_cmd_ready = 1'b1;
                    n_cmd       = i_cmd;
                    n_out       = '{data: '0, status: STS_OK};
                    unique case (i_cmd.kind)
                        CMD_ENQ: begin
                            if (full) begin
                                n_out_valid  = 1'b1;
                                n_out.status = STS_FULL;
                            end else if (r_bc == '0) begin
                                b_we        = 1'b1;
                                b_wd        = '{maxv: i_cmd.value, val: i_cmd.value};
                                n_bc        = r_bc + 1'b1;
                                n_out_valid = 1'b1;
                            end else begin
                                n_state = ST_ENQ;
                            end
                        end
                        CMD_DEQ: begin
                            if (r_fc != '0) begin
                                n_state = ST_DEQ;
                            end else if (r_bc == '0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = STS_EMPTY;
                            end else begin
                                n_state = ST_XRD;
                            end
                        end
                        CMD_MAX: begin
                            if (r_fc == '0 && r_bc == '0) begin
                                n_out_valid  = 1'b1;
                                n_out.status = STS_EMPTY;
                            end else begin
                                n_state = ST_MAX;
                            end
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            ST_ENQ: begin
                b_we        = 1'b1;
                b_wd        = '{maxv: f_max(r_back_rd.maxv, r_cmd.value), val: r_cmd.value};
                n_bc        = r_bc + 1'b1;
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_DEQ: begin
                n_fc        = r_fc - 1'b1;
                n_out_valid = 1'b1;
                n_out.data  = r_front_rd.val;
                n_state     = ST_IDLE;
            end
            ST_XRD: begin
                n_bc    = r_bc - 1'b1;
                n_state = ST_XWR;
            end
            ST_XWR: begin
                if (r_bc == '0) begin
                    // last word moved is the oldest: hand it out, no push
                    n_out_valid = 1'b1;
                    n_out.data  = xv;
                    n_state     = ST_IDLE;
                end else begin
                    f_we    = 1'b1;
                    f_wd    = '{maxv: xmax, val: xv};
                    n_fc    = r_fc + 1'b1;
                    n_run   = xmax;
                    n_state = ST_XRD;
                end
            end
            ST_MAX: begin
                n_out_valid = 1'b1;
                if (r_fc == '0) begin
                    n_out.data = r_back_rd.maxv;
                end else if (r_bc == '0) begin
                    n_out.data = r_front_rd.maxv;
                end else begin
                    n_out.data = f_max(r_front_rd.maxv, r_back_rd.maxv);
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fc        <= '0;
            r_bc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fc        <= n_fc;
            r_bc        <= n_bc;
            r_out_valid <= n_out_valid;
        end
        r_run <= n_run;
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (f_we) begin
            r_front_mem[f_wa] <= f_wd;
        end
        r_front_rd <= r_front_mem[f_ra];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            r_back_mem[b_wa] <= b_wd;
        end
        r_back_rd <= r_back_mem[b_ra];
    end

endmodule

// File: rtl/max_queue_two_stack.sv
// ----------------------------------------------------------------------------
// max_queue_two_stack
// FIFO of signed words with a running maximum, built from two stacks.
//
//   channel  valid        ready        word
//   in       i_in_valid   o_in_ready   i_in_word  (operation, value)
//   out      o_out_valid  i_out_ready  o_out_word (data, status)
//
// Enqueue, max and non-empty-front dequeue pass from IDLE through ENQ, MAX
// or DEQ in the back stage; enqueue onto an empty back stack and error
// results are answered from IDLE. A dequeue on an empty front stack moves
// the back stack across word by word through XRD and XWR, set by the
// registered back stack memory read, whose address follows the back count.
// A two-entry command queue lets input words be taken while the back stage
// works or while its result waits on i_out_ready.
// Reset is synchronous; no memory clearing is needed.
// ----------------------------------------------------------------------------
module max_queue_two_stack
    import mqts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic fr_valid;
    logic fr_ready;
    t_cmd fr_cmd;
    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;

    mqts_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_cmd_valid (fr_valid),
        .i_cmd_ready (fr_ready),
        .o_cmd       (fr_cmd)
    );

    mqts_cmdq u_cmdq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fr_valid),
        .o_wr_ready (fr_ready),
        .i_wr_cmd   (fr_cmd),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_cmd   (q_cmd)
    );

    mqts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
